>>> src/itp_pkg.sv
// shared types, character codes and decode functions for the infix to postfix converter
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

    typedef logic [2:0] op_code_t;

    localparam op_code_t CODE_LPAREN = 3'd0;
    localparam op_code_t CODE_PLUS   = 3'd1;
    localparam op_code_t CODE_MINUS  = 3'd2;
    localparam op_code_t CODE_MUL    = 3'd3;
    localparam op_code_t CODE_DIV    = 3'd4;
    localparam op_code_t CODE_POW    = 3'd5;
    localparam op_code_t CODE_NONE   = 3'd7;

    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_MUL    = 8'h2A;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_DIV    = 8'h2F;
    localparam logic [7:0] CHAR_POW    = 8'h5E;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_UA     = 8'h41;
    localparam logic [7:0] CHAR_UZ     = 8'h5A;
    localparam logic [7:0] CHAR_LA     = 8'h61;
    localparam logic [7:0] CHAR_LZ     = 8'h7A;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    function automatic op_code_t classify(input logic [7:0] ch);
        op_code_t c;
        case (ch)
            CHAR_PLUS:  c = CODE_PLUS;
            CHAR_MINUS: c = CODE_MINUS;
            CHAR_MUL:   c = CODE_MUL;
            CHAR_DIV:   c = CODE_DIV;
            CHAR_POW:   c = CODE_POW;
            default:    c = CODE_NONE;
        endcase
        return c;
    endfunction

    function automatic logic is_operand(input logic [7:0] ch);
        return (ch inside {[CHAR_UA:CHAR_UZ], [CHAR_LA:CHAR_LZ], [CHAR_0:CHAR_9]});
    endfunction

    function automatic logic [1:0] code_prec(input op_code_t c);
        logic [1:0] p;
        case (c)
            CODE_PLUS, CODE_MINUS: p = 2'd1;
            CODE_MUL, CODE_DIV:    p = 2'd2;
            CODE_POW:              p = 2'd3;
            default:               p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] code_char(input op_code_t c);
        logic [7:0] ch;
        case (c)
            CODE_PLUS:  ch = CHAR_PLUS;
            CODE_MINUS: ch = CHAR_MINUS;
            CODE_MUL:   ch = CHAR_MUL;
            CODE_DIV:   ch = CHAR_DIV;
            CODE_POW:   ch = CHAR_POW;
            default:    ch = CHAR_LPAREN;
        endcase
        return ch;
    endfunction

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_READ     = 6'b000100,
        ST_FLUSHCHK = 6'b001000,
        ST_FLUSH    = 6'b010000,
        ST_MARK     = 6'b100000
    } state_t;

endpackage

>>> src/infix_to_postfix_converter.sv
// infix to postfix converter: operator stack in a synchronous memory with a sequencer
// an operand goes from the input register through the dispatch state into the output register
// one item is taken at a time: s_ready is high only in the idle state, so a new item is
// taken only once the previous one, with any end-of-expression flush and end marker, is done
// pops stall while the output register holds an item not yet taken
// reset: synchronous active-low aresetn empties the stack; stack memory has no reset
module infix_to_postfix_converter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_symbol,
    input  logic       s_end_of_expression,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_symbol,
    output logic       m_out_valid,
    output logic       m_out_last
);

    itp_pkg::state_t state_reg, state_next;

    logic [itp_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [itp_pkg::CNT_W-1:0]  count_dec;
    logic [itp_pkg::CNT_W-1:0]  rd_cnt;
    logic [itp_pkg::ADDR_W-1:0] rd_addr;
    logic [itp_pkg::ADDR_W-1:0] wr_addr;
    itp_pkg::op_code_t          wr_data;
    logic                       mem_we;
    itp_pkg::op_code_t          rd_data_reg;
    itp_pkg::op_code_t          stack_mem [itp_pkg::STACK_DEPTH];

    logic [7:0] sym_reg;
    logic       eoe_reg;
    itp_pkg::op_code_t sym_code;
    itp_pkg::op_code_t top_code;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_sym_reg, m_sym_next;
    logic       m_ov_reg, m_ov_next;
    logic       m_last_reg, m_last_next;
    logic       out_free;
    logic       push_ok;

    assign s_ready      = (state_reg == itp_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_out_symbol = m_sym_reg;
    assign m_out_valid  = m_ov_reg;
    assign m_out_last   = m_last_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign sym_code  = itp_pkg::classify(sym_reg);
    assign top_code  = rd_data_reg;
    assign count_dec = count_reg - itp_pkg::CNT_W'(1);
    assign push_ok   = (count_reg < itp_pkg::DEPTH_CNT);
    assign wr_addr   = count_reg[itp_pkg::ADDR_W-1:0];
    assign rd_cnt    = count_next - itp_pkg::CNT_W'(1);
    assign rd_addr   = (count_next == '0) ? '0 : rd_cnt[itp_pkg::ADDR_W-1:0];

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        mem_we       = 1'b0;
        wr_data      = sym_code;
        m_valid_next = m_valid_reg && !m_ready;
        m_sym_next   = m_sym_reg;
        m_ov_next    = m_ov_reg;
        m_last_next  = m_last_reg;
        case (state_reg)
            itp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = itp_pkg::ST_DISPATCH;
                end
            end
            itp_pkg::ST_DISPATCH: begin
                if (itp_pkg::is_operand(sym_reg)) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_sym_next   = sym_reg;
                        m_ov_next    = 1'b1;
                        m_last_next  = 1'b0;
                        state_next   = itp_pkg::ST_FLUSHCHK;
                    end
                end else if (sym_reg == itp_pkg::CHAR_LPAREN) begin
                    if (push_ok) begin
                        mem_we     = 1'b1;
                        wr_data    = itp_pkg::CODE_LPAREN;
                        count_next = count_reg + itp_pkg::CNT_W'(1);
                    end
                    state_next = itp_pkg::ST_FLUSHCHK;
                end else if (sym_reg == itp_pkg::CHAR_RPAREN ||
                             sym_code != itp_pkg::CODE_NONE) begin
                    state_next = itp_pkg::ST_READ;
                end else begin
                    state_next = itp_pkg::ST_FLUSHCHK;
                end
            end
            itp_pkg::ST_READ: begin
                if (count_reg == '0) begin
                    if (sym_reg != itp_pkg::CHAR_RPAREN) begin
                        mem_we     = 1'b1;
                        count_next = count_reg + itp_pkg::CNT_W'(1);
                    end
                    state_next = itp_pkg::ST_FLUSHCHK;
                end else if (sym_reg == itp_pkg::CHAR_RPAREN &&
                             top_code == itp_pkg::CODE_LPAREN) begin
                    count_next = count_dec;
                    state_next = itp_pkg::ST_FLUSHCHK;
                end else if (sym_reg != itp_pkg::CHAR_RPAREN &&
                             itp_pkg::code_prec(top_code) < itp_pkg::code_prec(sym_code)) begin
                    if (push_ok) begin
                        mem_we     = 1'b1;
                        count_next = count_reg + itp_pkg::CNT_W'(1);
                    end
                    state_next = itp_pkg::ST_FLUSHCHK;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sym_next   = itp_pkg::code_char(top_code);
                    m_ov_next    = 1'b1;
                    m_last_next  = 1'b0;
                    count_next   = count_dec;
                end
            end
            itp_pkg::ST_FLUSHCHK: begin
                if (!eoe_reg) begin
                    state_next = itp_pkg::ST_IDLE;
                end else if (count_reg == '0) begin
                    state_next = itp_pkg::ST_MARK;
                end else begin
                    state_next = itp_pkg::ST_FLUSH;
                end
            end
            itp_pkg::ST_FLUSH: begin
                if (count_reg == '0) begin
                    state_next = itp_pkg::ST_MARK;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sym_next   = itp_pkg::code_char(top_code);
                    m_ov_next    = 1'b1;
                    m_last_next  = 1'b0;
                    count_next   = count_dec;
                end
            end
            itp_pkg::ST_MARK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sym_next   = itp_pkg::CHAR_NUL;
                    m_ov_next    = 1'b0;
                    m_last_next  = 1'b1;
                    state_next   = itp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = itp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= itp_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_sym_reg  <= m_sym_next;
        m_ov_reg   <= m_ov_next;
        m_last_reg <= m_last_next;
        if (s_valid && s_ready) begin
            sym_reg <= s_symbol;
            eoe_reg <= s_end_of_expression;
        end
    end

    // operator stack, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= itp_pkg::DEPTH_CNT)
        else $error("stack count beyond depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (count_reg < itp_pkg::DEPTH_CNT) && (count_next == count_reg + 1'b1))
        else $error("push without room or count not advanced");

    a_marker_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == itp_pkg::ST_MARK) |-> (count_reg == '0))
        else $error("end marker with stack not empty");

    a_marker_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_last) |-> (!m_out_valid && m_out_symbol == itp_pkg::CHAR_NUL))
        else $error("malformed end marker");

endmodule

>>> bench/infix_to_postfix_converter_tb.sv
// testbench for the infix to postfix converter: operator stack tracker, scoreboard, random traffic
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;

    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEM_TARGET  = 420;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       is_last;
    } postfix_char_t;

    typedef struct packed {
        logic [7:0] sym;
        logic       eoe;
    } infix_char_t;

    class postfix_tracker;
        itp_pkg::op_code_t pending_ops[itp_pkg::STACK_DEPTH];
        int unsigned       depth_in_use = 0;
        postfix_char_t     postfix_due[$];
        int unsigned       errors = 0;

        function int unsigned rank(itp_pkg::op_code_t c);
            case (c)
                itp_pkg::CODE_PLUS, itp_pkg::CODE_MINUS: return 1;
                itp_pkg::CODE_MUL, itp_pkg::CODE_DIV:    return 2;
                itp_pkg::CODE_POW:                       return 3;
                default:                                 return 0;
            endcase
        endfunction

        function itp_pkg::op_code_t operator_of(logic [7:0] ch);
            case (ch)
                itp_pkg::CHAR_PLUS:  return itp_pkg::CODE_PLUS;
                itp_pkg::CHAR_MINUS: return itp_pkg::CODE_MINUS;
                itp_pkg::CHAR_MUL:   return itp_pkg::CODE_MUL;
                itp_pkg::CHAR_DIV:   return itp_pkg::CODE_DIV;
                itp_pkg::CHAR_POW:   return itp_pkg::CODE_POW;
                default:             return itp_pkg::CODE_NONE;
            endcase
        endfunction

        function logic [7:0] glyph(itp_pkg::op_code_t c);
            case (c)
                itp_pkg::CODE_PLUS:  return itp_pkg::CHAR_PLUS;
                itp_pkg::CODE_MINUS: return itp_pkg::CHAR_MINUS;
                itp_pkg::CODE_MUL:   return itp_pkg::CHAR_MUL;
                itp_pkg::CODE_DIV:   return itp_pkg::CHAR_DIV;
                itp_pkg::CODE_POW:   return itp_pkg::CHAR_POW;
                default:             return itp_pkg::CHAR_LPAREN;
            endcase
        endfunction

        function void expect_char(logic [7:0] ch, logic has_char, logic is_last);
            postfix_char_t r;
            r.ch = ch;
            r.has_char = has_char;
            r.is_last = is_last;
            postfix_due.push_back(r);
        endfunction

        function void unwind_top();
            depth_in_use--;
            expect_char(glyph(pending_ops[depth_in_use]), 1'b1, 1'b0);
        endfunction

        function void stash(itp_pkg::op_code_t c);
            if (depth_in_use < itp_pkg::STACK_DEPTH) begin
                pending_ops[depth_in_use] = c;
                depth_in_use++;
            end
        endfunction

        function void take_infix_char(logic [7:0] ch, logic eoe);
            itp_pkg::op_code_t op;
            op = operator_of(ch);
            if ((ch >= itp_pkg::CHAR_UA && ch <= itp_pkg::CHAR_UZ) ||
                (ch >= itp_pkg::CHAR_LA && ch <= itp_pkg::CHAR_LZ) ||
                (ch >= itp_pkg::CHAR_0 && ch <= itp_pkg::CHAR_9)) begin
                expect_char(ch, 1'b1, 1'b0);
            end else if (ch == itp_pkg::CHAR_LPAREN) begin
                stash(itp_pkg::CODE_LPAREN);
            end else if (ch == itp_pkg::CHAR_RPAREN) begin
                while (depth_in_use > 0 &&
                       pending_ops[depth_in_use - 1] != itp_pkg::CODE_LPAREN)
                    unwind_top();
                if (depth_in_use > 0)
                    depth_in_use--;
            end else if (op != itp_pkg::CODE_NONE) begin
                while (depth_in_use > 0 && rank(pending_ops[depth_in_use - 1]) >= rank(op))
                    unwind_top();
                stash(op);
            end
            if (eoe) begin
                while (depth_in_use > 0)
                    unwind_top();
                expect_char(itp_pkg::CHAR_NUL, 1'b0, 1'b1);
            end
        endfunction

        function void match_postfix_char(logic [7:0] ch, logic has_char, logic is_last);
            postfix_char_t want;
            if (postfix_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result: symbol %h valid %b last %b",
                             ch, has_char, is_last);
                return;
            end
            want = postfix_due.pop_front();
            if (want.ch !== ch || want.has_char !== has_char || want.is_last !== is_last) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch: expected symbol %h valid %b last %b, got %h %b %b",
                             want.ch, want.has_char, want.is_last, ch, has_char, is_last);
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_symbol;
    logic       s_end_of_expression;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_symbol;
    logic       m_out_valid;
    logic       m_out_last;

    postfix_tracker tracker = new;
    infix_char_t    infix_chars[$];
    int unsigned    useful_items = 0;
    int unsigned    idle_cycles = 0;

    infix_to_postfix_converter DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_symbol            (s_symbol),
        .s_end_of_expression (s_end_of_expression),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_out_symbol        (m_out_symbol),
        .m_out_valid         (m_out_valid),
        .m_out_last          (m_out_last)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.take_infix_char(s_symbol, s_end_of_expression);
            if (m_valid && m_ready)
                tracker.match_postfix_char(m_out_symbol, m_out_valid, m_out_last);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("infix_to_postfix_converter_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_char(logic [7:0] sym, logic eoe = 1'b0);
        infix_char_t c;
        c.sym = sym;
        c.eoe = eoe;
        infix_chars.push_back(c);
        useful_items++;
    endtask

    task automatic queue_noise();
        infix_char_t c;
        c.sym = 8'($urandom_range(0, 255));
        c.eoe = 1'b0;
        infix_chars.push_back(c);
    endtask

    function automatic logic [7:0] any_operand();
        case ($urandom_range(0, 2))
            0:       return itp_pkg::CHAR_UA + 8'($urandom_range(0, 25));
            1:       return itp_pkg::CHAR_LA + 8'($urandom_range(0, 25));
            default: return itp_pkg::CHAR_0 + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [7:0] any_operator();
        case ($urandom_range(0, 4))
            0:       return itp_pkg::CHAR_PLUS;
            1:       return itp_pkg::CHAR_MINUS;
            2:       return itp_pkg::CHAR_MUL;
            3:       return itp_pkg::CHAR_DIV;
            default: return itp_pkg::CHAR_POW;
        endcase
    endfunction

    function automatic logic [7:0] any_special();
        case ($urandom_range(0, 4))
            0:       return itp_pkg::CHAR_LPAREN;
            1:       return itp_pkg::CHAR_RPAREN;
            2:       return any_operator();
            3:       return any_operand();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_directed();
        queue_char(itp_pkg::CHAR_NUL, 1'b1);
        queue_char(itp_pkg::CHAR_LA);
        queue_char(itp_pkg::CHAR_PLUS);
        queue_char(itp_pkg::CHAR_LPAREN);
        queue_char(itp_pkg::CHAR_UZ);
        queue_char(itp_pkg::CHAR_MUL);
        queue_char(itp_pkg::CHAR_9);
        queue_char(itp_pkg::CHAR_DIV);
        queue_char(itp_pkg::CHAR_0);
        queue_char(itp_pkg::CHAR_POW);
        queue_char(itp_pkg::CHAR_LZ);
        queue_char(itp_pkg::CHAR_RPAREN);
        queue_char(itp_pkg::CHAR_MINUS);
        queue_char(itp_pkg::CHAR_UA);
        queue_char(itp_pkg::CHAR_RPAREN);
        queue_char(itp_pkg::CHAR_POW);
        queue_char(8'hFF);
        queue_char(itp_pkg::CHAR_LPAREN);
        queue_char(itp_pkg::CHAR_LPAREN, 1'b1);
        queue_char(itp_pkg::CHAR_RPAREN, 1'b1);
        queue_char(itp_pkg::CHAR_MUL);
        queue_char(itp_pkg::CHAR_DIV);
        queue_char(itp_pkg::CHAR_POW);
        queue_char(itp_pkg::CHAR_POW);
        queue_char(itp_pkg::CHAR_LA + 8'd23, 1'b1);
    endtask

    task automatic queue_expression();
        int opened;
        int terms;
        int n;
        opened = 0;
        if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n - 1; i++)
                queue_char(any_special());
            queue_char(any_special(), 1'b1);
            return;
        end
        if ($urandom_range(0, 11) == 0) begin
            n = $urandom_range(28, 40);
            for (int i = 0; i < n; i++) begin
                queue_char(itp_pkg::CHAR_LPAREN);
                if ($urandom_range(0, 3) == 0) begin
                    queue_char(any_operand());
                    queue_char(any_operator());
                end
            end
            opened = n;
        end
        terms = $urandom_range(1, 8);
        for (int t = 0; t < terms; t++) begin
            while ($urandom_range(0, 3) == 0) begin
                queue_char(itp_pkg::CHAR_LPAREN);
                opened++;
            end
            queue_char(any_operand());
            if ($urandom_range(0, 15) == 0)
                queue_noise();
            while (opened > 0 && $urandom_range(0, 2) == 0) begin
                queue_char(itp_pkg::CHAR_RPAREN);
                opened--;
            end
            if (t < terms - 1)
                queue_char(any_operator());
        end
        if ($urandom_range(0, 3) != 0) begin
            while (opened > 0) begin
                queue_char(itp_pkg::CHAR_RPAREN);
                opened--;
            end
        end
        if ($urandom_range(0, 9) == 0)
            queue_char(itp_pkg::CHAR_RPAREN);
        case ($urandom_range(0, 9))
            0:       queue_char(8'($urandom_range(0, 255)), 1'b1);
            1:       queue_char(any_operator(), 1'b1);
            default: infix_chars[$].eoe = 1'b1;
        endcase
    endtask

    task automatic drive_items();
        int gap;
        int quiet_left;
        quiet_left = 0;
        foreach (infix_chars[i]) begin
            if (quiet_left > 0) begin
                quiet_left--;
                gap = 0;
            end else begin
                gap = pause_len();
                if ($urandom_range(0, 29) == 0)
                    quiet_left = $urandom_range(20, 60);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_symbol <= infix_chars[i].sym;
            s_end_of_expression <= infix_chars[i].eoe;
            do
                @(posedge aclk);
            while (!s_ready);
            @(negedge aclk);
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            m_ready <= ($urandom_range(0, 2) != 0);
            repeat (1 + pause_len()) @(negedge aclk);
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_symbol = 8'h00;
        s_end_of_expression = 1'b0;
        queue_directed();
        while (useful_items < ITEM_TARGET)
            queue_expression();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        drive_items();
        while (tracker.postfix_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.postfix_due.size() == 0)
            $display("infix_to_postfix_converter_tb passed");
        else
            $display("infix_to_postfix_converter_tb failed");
        $finish;
    end

endmodule
